// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the converter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/dncd_pkg.sv -----
// ----------------------------------------------------------------------------
// dncd_pkg
// Types, constants and small tables for the day number to date converter.
// ----------------------------------------------------------------------------
package dncd_pkg;

    // Width of the incoming day count
    localparam int unsigned DAY_NUMBER_BITS = 16;

    typedef logic [DAY_NUMBER_BITS-1:0] day_count_t;

    // Start of the count: 1 January 1990, a Monday
    localparam logic [11:0] BASE_YEAR      = 12'd1990;
    localparam logic [1:0]  BASE_MOD4      = 2'd2;
    localparam logic [6:0]  BASE_MOD100    = 7'd90;
    localparam logic [8:0]  BASE_MOD400    = 9'd390;
    localparam logic [2:0]  BASE_WEEKDAY   = 3'd1;
    localparam logic [8:0]  YEAR_DAYS      = 9'd365;
    localparam logic [6:0]  LAST_MOD100    = 7'd99;
    localparam logic [8:0]  LAST_MOD400    = 9'd399;
    localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    // Outcome of one compare-and-subtract step
    typedef struct packed {
        logic       ge;
        day_count_t diff;
    } sub_result_t;

    // Length of a month, index 0 = January
    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        begin
            unique case (idx) inside
                4'd1:                      len = leap ? 5'd29 : 5'd28;
                4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Residue mod 7 of a value below 32
    function automatic logic [2:0] mod7_small(input logic [4:0] v);
        logic [4:0] r;
        begin
            r = v;
            if (r >= 5'd28)      r = r - 5'd28;
            else if (r >= 5'd21) r = r - 5'd21;
            else if (r >= 5'd14) r = r - 5'd14;
            else if (r >= 5'd7)  r = r - 5'd7;
            return r[2:0];
        end
    endfunction

    // Sum of a weekday and a small offset, folded back into 0..6
    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] inc);
        logic [3:0] s;
        begin
            s = {1'b0, wd} + {1'b0, inc};
            if (s >= 4'd7) s = s - 4'd7;
            return s[2:0];
        end
    endfunction

endpackage

// ----- rtl/dncd_in_if.sv -----
// ----------------------------------------------------------------------------
// dncd_in_if
// Input channel: one day count per transaction.
// ----------------------------------------------------------------------------
interface dncd_in_if;
    logic                  valid;
    logic                  ready;
    dncd_pkg::day_count_t  day_number;

    modport source (output valid, output day_number, input ready);
    modport sink   (input valid, input day_number, output ready);
endinterface

// ----- rtl/dncd_out_if.sv -----
// ----------------------------------------------------------------------------
// dncd_out_if
// Output channel: one calendar date per transaction.
// ----------------------------------------------------------------------------
interface dncd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  weekday;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;

    modport source (output valid, output weekday, output day_of_month, output month,
                    output year, input ready);
    modport sink   (input valid, input weekday, input day_of_month, input month,
                    input year, output ready);
endinterface

// ----- rtl/dncd_sub.sv -----
// ----------------------------------------------------------------------------
// dncd_sub
// Shared compare-and-subtract unit used for both year and month steps.
// ----------------------------------------------------------------------------
module dncd_sub (
    input  dncd_pkg::day_count_t  left,
    input  dncd_pkg::day_count_t  len,
    output dncd_pkg::sub_result_t res
);

    // Compare the remaining count against the period length, form the difference
    always_comb
    begin
        res.ge   = (left >= len);
        res.diff = left - len;
    end

endmodule

// ----- rtl/day_number_to_calendar_date.sv -----
// ----------------------------------------------------------------------------
// day_number_to_calendar_date
// Converts a day count since 1 January 1990 into weekday, day, month, year.
// ----------------------------------------------------------------------------
// Usage:
//   days : day_number in, valid/ready. The block is ready only when idle, so
//          one transaction is converted at a time.
//   date : weekday, day_of_month, month, year out, valid/ready, held in an
//          output register; a new count is taken while a date still waits.
//   Sequence: the year state steps off whole years (up to 179 for a 16-bit
//   count) until its compare fails, then the month state steps off whole
//   months (up to 11) until a compare fails or December is reached; the final
//   state loads the output. The single compare-and-subtract unit serves every
//   step, and a new count is taken only after the date has been loaded.
//   Reset: the sequencer returns to idle and the output valid clears.
//   Stall: a finished date waits in its final state until the output register
//   is free, then the block is ready again.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module day_number_to_calendar_date (
    input  logic               clk,
    input  logic               rst_n,
    dncd_in_if.sink            days,
    dncd_out_if.source         date
);

    dncd_pkg::state_t      state_reg,   state_next;
    dncd_pkg::day_count_t  left_reg,    left_next;
    logic [11:0]           year_reg,    year_next;
    logic [1:0]            mod4_reg,    mod4_next;
    logic [6:0]            mod100_reg,  mod100_next;
    logic [8:0]            mod400_reg,  mod400_next;
    logic [3:0]            mo_reg,      mo_next;
    logic [2:0]            wd_reg,      wd_next;
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            out_wd_reg,  out_wd_next;
    logic [4:0]            out_dom_reg, out_dom_next;
    logic [3:0]            out_mo_reg,  out_mo_next;
    logic [11:0]           out_yr_reg,  out_yr_next;

    logic                  leap;
    logic [4:0]            mlen;
    logic [8:0]            ylen;
    dncd_pkg::day_count_t  step_len;
    dncd_pkg::sub_result_t step;
    logic                  out_free;

    logic                  residues_ok;
    logic                  in_done;
    logic                  month_ok;
    logic                  date_ok;
    logic                  out_stall;
    logic [24:0]           date_word;

    // Leap rule from the running residues of the year
    assign leap = (mod4_reg == 2'd0) && ((mod100_reg != 7'd0) || (mod400_reg == 9'd0));
    assign ylen = dncd_pkg::YEAR_DAYS + {8'd0, leap};
    assign mlen = dncd_pkg::month_len(mo_reg, leap);

    // Select the period length for the shared unit
    assign step_len = (state_reg == dncd_pkg::ST_YEAR) ? dncd_pkg::day_count_t'(ylen)
                                                       : dncd_pkg::day_count_t'(mlen);

    dncd_sub u_sub (
        .left (left_reg),
        .len  (step_len),
        .res  (step)
    );

    assign out_free   = !out_valid_reg || date.ready;
    assign days.ready = (state_reg == dncd_pkg::ST_IDLE);

    assign date.valid        = out_valid_reg;
    assign date.weekday      = out_wd_reg;
    assign date.day_of_month = out_dom_reg;
    assign date.month        = out_mo_reg;
    assign date.year         = out_yr_reg;

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dncd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold working and output payload
    always_ff @(posedge clk)
    begin
        left_reg    <= left_next;
        year_reg    <= year_next;
        mod4_reg    <= mod4_next;
        mod100_reg  <= mod100_next;
        mod400_reg  <= mod400_next;
        mo_reg      <= mo_next;
        wd_reg      <= wd_next;
        out_wd_reg  <= out_wd_next;
        out_dom_reg <= out_dom_next;
        out_mo_reg  <= out_mo_next;
        out_yr_reg  <= out_yr_next;
    end

    // Sequence the year steps, the month steps and the output load
    always_comb
    begin
        state_next     = state_reg;
        left_next      = left_reg;
        year_next      = year_reg;
        mod4_next      = mod4_reg;
        mod100_next    = mod100_reg;
        mod400_next    = mod400_reg;
        mo_next        = mo_reg;
        wd_next        = wd_reg;
        out_valid_next = out_valid_reg && !date.ready;
        out_wd_next    = out_wd_reg;
        out_dom_next   = out_dom_reg;
        out_mo_next    = out_mo_reg;
        out_yr_next    = out_yr_reg;

        unique case (state_reg)
            dncd_pkg::ST_IDLE:
            begin
                if (days.valid)
                begin
                    left_next   = days.day_number;
                    year_next   = dncd_pkg::BASE_YEAR;
                    mod4_next   = dncd_pkg::BASE_MOD4;
                    mod100_next = dncd_pkg::BASE_MOD100;
                    mod400_next = dncd_pkg::BASE_MOD400;
                    wd_next     = dncd_pkg::BASE_WEEKDAY;
                    state_next  = dncd_pkg::ST_YEAR;
                end
            end

            dncd_pkg::ST_YEAR:
            begin
                if (step.ge)
                begin
                    // Drop one whole year and advance to 1 January of the next
                    left_next   = step.diff;
                    year_next   = year_reg + 12'd1;
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == dncd_pkg::LAST_MOD100) ? 7'd0
                                                                        : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == dncd_pkg::LAST_MOD400) ? 9'd0
                                                                        : mod400_reg + 9'd1;
                    wd_next     = dncd_pkg::wd_add(wd_reg, {1'b0, leap, !leap});
                end
                else
                begin
                    mo_next    = 4'd0;
                    state_next = dncd_pkg::ST_MONTH;
                end
            end

            dncd_pkg::ST_MONTH:
            begin
                if ((mo_reg < dncd_pkg::LAST_MONTH_IDX) && step.ge)
                begin
                    // Drop one whole month; its length beyond four weeks shifts the weekday
                    left_next = step.diff;
                    mo_next   = mo_reg + 4'd1;
                    wd_next   = dncd_pkg::wd_add(wd_reg, mlen[2:0] - 3'd4);
                end
                else
                begin
                    state_next = dncd_pkg::ST_DONE;
                end
            end

            dncd_pkg::ST_DONE:
            begin
                // Load the date once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_wd_next    = dncd_pkg::wd_add(wd_reg,
                                                      dncd_pkg::mod7_small(left_reg[4:0]));
                    out_dom_next   = left_reg[4:0] + 5'd1;
                    out_mo_next    = mo_reg + 4'd1;
                    out_yr_next    = year_reg;
                    state_next     = dncd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dncd_pkg::ST_IDLE;
            end
        endcase
    end

    // Terms for the checks below
    assign residues_ok = (state_reg == dncd_pkg::ST_IDLE) || (mod4_reg == mod100_reg[1:0]);
    assign in_done     = (state_reg == dncd_pkg::ST_DONE);
    assign month_ok    = (state_reg != dncd_pkg::ST_MONTH) ||
                         (mo_reg <= dncd_pkg::LAST_MONTH_IDX);
    assign date_ok     = (date.weekday != 3'd7) && (date.day_of_month != 5'd0);
    assign out_stall   = date.valid && !date.ready;
    assign date_word   = {date.valid, date.weekday, date.day_of_month, date.month, date.year};

    // The year residues mod 4 and mod 100 must agree
    `ASSERT_CLKD(a_residues_agree, clk, rst_n, residues_ok, "year residues out of step")
    // Output valid rises only out of the final state
    `ASSERT_CLKD(a_valid_from_done, clk, rst_n, $rose(date.valid) |-> $past(in_done), "stray date")
    // Month index never passes December while months are stepped off
    `ASSERT_CLKD(a_month_bound, clk, rst_n, month_ok, "month index out of range")
    // A delivered date carries a legal weekday and day of month
    `ASSERT_CLKD(a_date_legal, clk, rst_n, date.valid |-> date_ok, "illegal date fields")
    // A waiting date is not overwritten
    `ASSERT_CLKD(a_out_hold, clk, rst_n, out_stall |=> $stable(date_word), "date overwritten")

endmodule

// ----- tb/day_number_to_calendar_date_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_number_to_calendar_date_tb
// Self-checking bench for the day count to calendar date converter. A table
// of directed counts is replayed first, covering the ends of the range, month
// and year edges, and the leap and century rules. Random counts follow.
// Each accepted count without a typed date is run through a local calendar
// model, and each output transaction is compared field by field with the
// oldest pending date. The sender runs in bursts with random gaps, and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module day_number_to_calendar_date_tb;

    localparam int unsigned RANDOM_DAYS  = 1550;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned LIMIT_CYCLES = 2_500_000;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic [2:0] {
        SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY
    } weekday_t;

    typedef enum logic [3:0] {
        JANUARY = 4'd1, FEBRUARY, MARCH, APRIL, MAY, JUNE,
        JULY, AUGUST, SEPTEMBER, OCTOBER, NOVEMBER, DECEMBER
    } month_t;

    typedef struct packed {
        logic [2:0]  weekday;
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_date_t;

    typedef struct {
        dncd_pkg::day_count_t day_number;
        bit                   typed;
        calendar_date_t       date;
    } stim_row_t;

    // Month lengths of a common year, January first
    int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // Offsets from 1 January that straddle the leap day and the year ends
    int year_edge_offsets [7] = '{-1, 0, 58, 59, 60, 364, 365};

    // Directed counts; a date is typed in only where it is known by heart
    stim_row_t directed_rows [21] = '{
        '{16'd0,     1'b1, '{MONDAY, 5'd1, JANUARY, 12'd1990}},
        '{16'd65535, 1'b1, '{TUESDAY, 5'd6, JUNE, 12'd2169}},
        '{16'd30,    1'b0, '0},
        '{16'd31,    1'b0, '0},
        '{16'd58,    1'b0, '0},
        '{16'd59,    1'b0, '0},
        '{16'd364,   1'b0, '0},
        '{16'd365,   1'b0, '0},
        '{16'd788,   1'b0, '0},
        '{16'd789,   1'b0, '0},
        '{16'd790,   1'b0, '0},
        '{16'd1095,  1'b0, '0},
        '{16'd3711,  1'b0, '0},
        '{16'd4017,  1'b0, '0},
        '{16'd40235, 1'b0, '0},
        '{16'd40236, 1'b0, '0},
        '{16'h5555,  1'b0, '0},
        '{16'hAAAA,  1'b0, '0},
        '{16'h7FFF,  1'b0, '0},
        '{16'h8000,  1'b0, '0},
        '{16'd65534, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    dncd_in_if  days_if ();
    dncd_out_if date_if ();

    calendar_date_t pending_dates [$];
    int unsigned    mismatch_count;
    int unsigned    cycle_count;
    int unsigned    burst_left;
    logic [9:0]     stall_phase;

    day_number_to_calendar_date dut (
        .clk   (clk),
        .rst_n (rst_n),
        .days  (days_if.sink),
        .date  (date_if.source)
    );

    // Clock: 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Step off whole years, then whole months, from 1 January 1990
    function automatic calendar_date_t civil_date_of(input dncd_pkg::day_count_t n);
        calendar_date_t d;
        int unsigned    rest;
        int unsigned    yr;
        int unsigned    ylen;
        int unsigned    mi;
        int unsigned    mlen;
        rest = n;
        yr   = 1990;
        ylen = 365 + leap_year(yr);
        while (rest >= ylen)
        begin
            rest -= ylen;
            yr++;
            ylen = 365 + leap_year(yr);
        end
        mi = 0;
        while (mi < 11)
        begin
            mlen = month_days[mi] + ((mi == 1 && leap_year(yr)) ? 1 : 0);
            if (rest < mlen)
                break;
            rest -= mlen;
            mi++;
        end
        d.weekday      = 3'((int'(n) + 1) % 7);
        d.day_of_month = 5'(rest + 1);
        d.month        = 4'(mi + 1);
        d.year         = 12'(yr);
        return d;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Present one count, hold it until taken, then pace the next burst
    task automatic offer_day(input dncd_pkg::day_count_t n, input bit typed,
                             input calendar_date_t typed_date);
        calendar_date_t want;
        want = typed ? typed_date : civil_date_of(n);
        days_if.valid      <= 1'b1;
        days_if.day_number <= n;
        do
            @(posedge clk);
        while (!days_if.ready);
        pending_dates.push_back(want);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            days_if.valid <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 220)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Receiver: free-running, light stalls, heavy stalls, fixed on/off
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 10'd1;
        case (stall_phase[9:8])
            2'd0:    date_if.ready <= 1'b1;
            2'd1:    date_if.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    date_if.ready <= ($urandom_range(0, 7) == 0);
            default: date_if.ready <= stall_phase[4];
        endcase
    end

    // Compare each output transaction with the oldest pending date
    always @(posedge clk)
    begin
        calendar_date_t want;
        if (rst_n && date_if.valid && date_if.ready)
        begin
            if (pending_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: unexpected date %0d-%0d-%0d", $realtime,
                             date_if.year, date_if.month, date_if.day_of_month);
            end
            else
            begin
                want = pending_dates.pop_front();
                check_field("weekday", want.weekday, date_if.weekday);
                check_field("day_of_month", want.day_of_month, date_if.day_of_month);
                check_field("month", want.month, date_if.month);
                check_field("year", want.year, date_if.year);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        dncd_pkg::day_count_t n;
        int unsigned yr;
        int unsigned acc;
        mismatch_count     = 0;
        cycle_count        = 0;
        burst_left         = 4;
        stall_phase        = '0;
        rst_n              = 1'b0;
        days_if.valid      = 1'b0;
        days_if.day_number = '0;
        date_if.ready      = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
            offer_day(directed_rows[i].day_number, directed_rows[i].typed,
                      directed_rows[i].date);

        // Random counts: uniform, early years, and year and leap-day edges
        for (int k = 0; k < RANDOM_DAYS; k++)
        begin
            case ($urandom_range(0, 9)) inside
                [0:4]:   n = dncd_pkg::day_count_t'($urandom_range(0, 65535));
                [5:6]:   n = dncd_pkg::day_count_t'($urandom_range(0, 2047));
                default:
                begin
                    yr  = $urandom_range(1991, 2168);
                    acc = 0;
                    for (int y = 1990; y < yr; y++)
                        acc += 365 + leap_year(y);
                    n = dncd_pkg::day_count_t'(int'(acc) +
                                               year_edge_offsets[$urandom_range(0, 6)]);
                end
            endcase
            offer_day(n, 1'b0, '0);

            // Hold off until every pending date is out
            if (k % 400 == 399)
            begin
                days_if.valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_dates.size() != 0);
            end
        end

        days_if.valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += pending_dates.size();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- day_number_to_calendar_date.f -----
+incdir+rtl
rtl/dncd_pkg.sv
rtl/dncd_in_if.sv
rtl/dncd_out_if.sv
rtl/dncd_sub.sv
rtl/day_number_to_calendar_date.sv
tb/day_number_to_calendar_date_tb.sv
